// File: design/skt_pkg.sv
package skt_pkg;

   localparam int MODE_W   = 3;
   localparam int KEY_W    = 32;
   localparam int INDEX_W  = 6;
   localparam int STATUS_W = 3;
   localparam int POS_W    = 6;
   localparam int COUNT_W  = 7;

   localparam logic [MODE_W-1:0] MODE_INSERT = 3'd0;
   localparam logic [MODE_W-1:0] MODE_UNIQUE = 3'd1;
   localparam logic [MODE_W-1:0] MODE_DELETE = 3'd2;
   localparam logic [MODE_W-1:0] MODE_FIND   = 3'd3;
   localparam logic [MODE_W-1:0] MODE_READ   = 3'd4;
   localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd5;

   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
   localparam logic [STATUS_W-1:0] ST_DUP       = 3'd3;
   localparam logic [STATUS_W-1:0] ST_RANGE     = 3'd4;

   typedef enum logic [2:0] {
      PTR_HOLD,
      PTR_ZERO,
      PTR_INDEX,
      PTR_COUNT,
      PTR_INC,
      PTR_DEC
   } ptr_op_type;

   typedef enum logic [1:0] {
      RD_SAME,
      RD_PREV,
      RD_NEXT
   } rd_off_type;

   typedef enum logic [1:0] {
      CNT_HOLD,
      CNT_CLEAR,
      CNT_INC,
      CNT_DEC
   } cnt_op_type;

   typedef enum logic [1:0] {
      WR_NONE,
      WR_SHIFT,
      WR_KEY
   } wr_sel_type;

   typedef struct packed {
      logic                load_req;
      ptr_op_type          ptr_op;
      rd_off_type          rd_off;
      cnt_op_type          cnt_op;
      wr_sel_type          wr_sel;
      logic                set_status;
      logic [STATUS_W-1:0] status;
      logic                load_pos;
      logic                load_kout;
      logic                load_rsp;
   } ctrl_cmd_type;

   typedef struct packed {
      logic full;
      logic idx_ok;
      logic at_end;
      logic key_gt;
      logic key_eq;
      logic at_pos;
      logic last;
   } dp_flags_type;

endpackage

// File: design/skt_if.sv
interface skt_req_if;
   logic                              valid;
   logic                              ready;
   logic [skt_pkg::MODE_W-1:0]        mode;
   logic signed [skt_pkg::KEY_W-1:0]  key;
   logic [skt_pkg::INDEX_W-1:0]       index;

   modport source (output valid, output mode, output key, output index, input ready);
   modport sink (input valid, input mode, input key, input index, output ready);
endinterface

interface skt_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [skt_pkg::STATUS_W-1:0]      status;
   logic [skt_pkg::POS_W-1:0]         position;
   logic signed [skt_pkg::KEY_W-1:0]  key_out;
   logic [skt_pkg::COUNT_W-1:0]       count;

   modport source (output valid, output status, output position, output key_out,
                   output count, input ready);
   modport sink (input valid, input status, input position, input key_out,
                 input count, output ready);
endinterface

// File: design/skt_ctrl.sv
module skt_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic [skt_pkg::MODE_W-1:0]  req_mode,
   output logic                        req_ready,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  skt_pkg::dp_flags_type       flags,
   output skt_pkg::ctrl_cmd_type       cmd
);

   typedef enum logic [2:0] {
      IDLE,
      SEARCH,
      SHIFT_UP,
      SHIFT_DN,
      READ,
      FINISH
   } state_type;

   state_type                   state_ff, state_in;
   logic [skt_pkg::MODE_W-1:0]  mode_ff, mode_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        stop;
   logic                        match;

   assign req_ready = (state_ff == IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      match = !flags.at_end && flags.key_eq;
      stop  = flags.at_end || flags.key_gt ||
              ((mode_ff != skt_pkg::MODE_INSERT) && flags.key_eq);
   end

   always_comb begin
      state_in   = state_ff;
      mode_in    = mode_ff;
      cmd.load_req   = 1'b0;
      cmd.ptr_op     = skt_pkg::PTR_HOLD;
      cmd.rd_off     = skt_pkg::RD_SAME;
      cmd.cnt_op     = skt_pkg::CNT_HOLD;
      cmd.wr_sel     = skt_pkg::WR_NONE;
      cmd.set_status = 1'b0;
      cmd.status     = skt_pkg::ST_OK;
      cmd.load_pos   = 1'b0;
      cmd.load_kout  = 1'b0;
      cmd.load_rsp   = 1'b0;

      unique case (state_ff)
         IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               mode_in      = req_mode;
               state_in     = FINISH;
               case (req_mode) inside
                  skt_pkg::MODE_INSERT, skt_pkg::MODE_UNIQUE: begin
                     if (flags.full) begin
                        cmd.set_status = 1'b1;
                        cmd.status     = skt_pkg::ST_FULL;
                     end else begin
                        cmd.ptr_op = skt_pkg::PTR_ZERO;
                        state_in   = SEARCH;
                     end
                  end
                  skt_pkg::MODE_DELETE, skt_pkg::MODE_FIND: begin
                     cmd.ptr_op = skt_pkg::PTR_ZERO;
                     state_in   = SEARCH;
                  end
                  skt_pkg::MODE_READ: begin
                     if (flags.idx_ok) begin
                        cmd.ptr_op = skt_pkg::PTR_INDEX;
                        state_in   = READ;
                     end else begin
                        cmd.set_status = 1'b1;
                        cmd.status     = skt_pkg::ST_RANGE;
                     end
                  end
                  skt_pkg::MODE_CLEAR: begin
                     cmd.cnt_op = skt_pkg::CNT_CLEAR;
                  end
                  default: begin
                  end
               endcase
            end
         end
         SEARCH: begin
            if (!stop) begin
               cmd.ptr_op = skt_pkg::PTR_INC;
            end else begin
               state_in = FINISH;
               case (mode_ff)
                  skt_pkg::MODE_INSERT: begin
                     cmd.load_pos = 1'b1;
                     cmd.ptr_op   = skt_pkg::PTR_COUNT;
                     cmd.rd_off   = skt_pkg::RD_PREV;
                     state_in     = SHIFT_UP;
                  end
                  skt_pkg::MODE_UNIQUE: begin
                     cmd.load_pos = 1'b1;
                     if (match) begin
                        cmd.set_status = 1'b1;
                        cmd.status     = skt_pkg::ST_DUP;
                     end else begin
                        cmd.ptr_op = skt_pkg::PTR_COUNT;
                        cmd.rd_off = skt_pkg::RD_PREV;
                        state_in   = SHIFT_UP;
                     end
                  end
                  skt_pkg::MODE_DELETE: begin
                     if (match) begin
                        cmd.load_pos = 1'b1;
                        cmd.rd_off   = skt_pkg::RD_NEXT;
                        state_in     = SHIFT_DN;
                     end else begin
                        cmd.set_status = 1'b1;
                        cmd.status     = skt_pkg::ST_NOT_FOUND;
                     end
                  end
                  default: begin
                     if (match) begin
                        cmd.load_pos = 1'b1;
                     end else begin
                        cmd.set_status = 1'b1;
                        cmd.status     = skt_pkg::ST_NOT_FOUND;
                     end
                  end
               endcase
            end
         end
         SHIFT_UP: begin
            if (flags.at_pos) begin
               cmd.wr_sel = skt_pkg::WR_KEY;
               cmd.cnt_op = skt_pkg::CNT_INC;
               state_in   = FINISH;
            end else begin
               cmd.wr_sel = skt_pkg::WR_SHIFT;
               cmd.ptr_op = skt_pkg::PTR_DEC;
               cmd.rd_off = skt_pkg::RD_PREV;
            end
         end
         SHIFT_DN: begin
            if (flags.last) begin
               cmd.cnt_op = skt_pkg::CNT_DEC;
               state_in   = FINISH;
            end else begin
               cmd.wr_sel = skt_pkg::WR_SHIFT;
               cmd.ptr_op = skt_pkg::PTR_INC;
               cmd.rd_off = skt_pkg::RD_NEXT;
            end
         end
         READ: begin
            cmd.load_kout = 1'b1;
            cmd.load_pos  = 1'b1;
            state_in      = FINISH;
         end
         FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               state_in     = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase

      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         mode_ff      <= skt_pkg::MODE_INSERT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: design/skt_datapath.sv
module skt_datapath #(
   parameter int DEPTH     = 64,
   parameter int KEY_WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic signed [skt_pkg::KEY_W-1:0]    req_key,
   input  logic [skt_pkg::INDEX_W-1:0]         req_index,
   input  skt_pkg::ctrl_cmd_type               cmd,
   output skt_pkg::dp_flags_type               flags,
   output logic [skt_pkg::STATUS_W-1:0]        rsp_status,
   output logic [skt_pkg::POS_W-1:0]           rsp_position,
   output logic signed [skt_pkg::KEY_W-1:0]    rsp_key_out,
   output logic [skt_pkg::COUNT_W-1:0]         rsp_count
);

   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int IDX_CW = (CNT_W > skt_pkg::INDEX_W) ? CNT_W : skt_pkg::INDEX_W;
   localparam int POS_CW = (CNT_W > skt_pkg::POS_W) ? CNT_W : skt_pkg::POS_W;
   localparam int OUT_CW = (CNT_W > skt_pkg::COUNT_W) ? CNT_W : skt_pkg::COUNT_W;

   logic signed [KEY_WIDTH-1:0]       mem [DEPTH];
   logic signed [KEY_WIDTH-1:0]       rd_data_ff;
   logic signed [KEY_WIDTH-1:0]       key_ff;
   logic signed [KEY_WIDTH-1:0]       wr_data;
   logic [CNT_W-1:0]                  ptr_ff, ptr_in;
   logic [CNT_W-1:0]                  count_ff, count_in;
   logic [CNT_W-1:0]                  pos_ff;
   logic [CNT_W-1:0]                  rd_full;
   logic [ADDR_W-1:0]                 rd_addr;
   logic [ADDR_W-1:0]                 wr_addr;
   logic                              wr_en;
   logic [skt_pkg::STATUS_W-1:0]      status_ff;
   logic signed [skt_pkg::KEY_W-1:0]  kout_ff;
   logic [skt_pkg::STATUS_W-1:0]      rsp_status_ff;
   logic [skt_pkg::POS_W-1:0]         rsp_position_ff;
   logic signed [skt_pkg::KEY_W-1:0]  rsp_key_out_ff;
   logic [skt_pkg::COUNT_W-1:0]       rsp_count_ff;
   logic [POS_CW-1:0]                 pos_ext;
   logic [OUT_CW-1:0]                 count_ext;

   always_comb begin
      case (cmd.ptr_op)
         skt_pkg::PTR_ZERO:  ptr_in = '0;
         skt_pkg::PTR_INDEX: ptr_in = CNT_W'(req_index);
         skt_pkg::PTR_COUNT: ptr_in = count_ff;
         skt_pkg::PTR_INC:   ptr_in = ptr_ff + 1'b1;
         skt_pkg::PTR_DEC:   ptr_in = ptr_ff - 1'b1;
         default:            ptr_in = ptr_ff;
      endcase

      case (cmd.rd_off)
         skt_pkg::RD_PREV: rd_full = ptr_in - 1'b1;
         skt_pkg::RD_NEXT: rd_full = ptr_in + 1'b1;
         default:          rd_full = ptr_in;
      endcase
      rd_addr = rd_full[ADDR_W-1:0];

      case (cmd.cnt_op)
         skt_pkg::CNT_CLEAR: count_in = '0;
         skt_pkg::CNT_INC:   count_in = count_ff + 1'b1;
         skt_pkg::CNT_DEC:   count_in = count_ff - 1'b1;
         default:            count_in = count_ff;
      endcase

      wr_en   = (cmd.wr_sel != skt_pkg::WR_NONE);
      wr_data = (cmd.wr_sel == skt_pkg::WR_KEY) ? key_ff : rd_data_ff;
      wr_addr = ptr_ff[ADDR_W-1:0];
   end

   always_comb begin
      flags.full   = (count_ff == CNT_W'(DEPTH));
      flags.idx_ok = (IDX_CW'(req_index) < IDX_CW'(count_ff));
      flags.at_end = (ptr_ff == count_ff);
      flags.key_gt = (rd_data_ff > key_ff);
      flags.key_eq = (rd_data_ff == key_ff);
      flags.at_pos = (ptr_ff == pos_ff);
      flags.last   = (CNT_W'(ptr_ff + 1'b1) == count_ff);
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff <= ptr_in;
      if (cmd.load_req) begin
         key_ff  <= KEY_WIDTH'(req_key);
         kout_ff <= '0;
      end else if (cmd.load_kout) begin
         kout_ff <= skt_pkg::KEY_W'(rd_data_ff);
      end
      if (cmd.set_status) begin
         status_ff <= cmd.status;
      end else if (cmd.load_req) begin
         status_ff <= skt_pkg::ST_OK;
      end
      if (cmd.load_pos) begin
         pos_ff <= ptr_ff;
      end else if (cmd.load_req) begin
         pos_ff <= '0;
      end
   end

   assign pos_ext   = POS_CW'(pos_ff);
   assign count_ext = OUT_CW'(count_ff);

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_status_ff   <= status_ff;
         rsp_position_ff <= pos_ext[skt_pkg::POS_W-1:0];
         rsp_key_out_ff  <= kout_ff;
         rsp_count_ff    <= count_ext[skt_pkg::COUNT_W-1:0];
      end
   end

   assign rsp_status   = rsp_status_ff;
   assign rsp_position = rsp_position_ff;
   assign rsp_key_out  = rsp_key_out_ff;
   assign rsp_count    = rsp_count_ff;

endmodule

// File: design/sorted_key_table.sv
// Insert scans to the slot, then shifts the upper entries up one per cycle and writes
// the key; delete scans to the match, then shifts the upper entries down; find scans
// to the match; read loads the entry; clear and refused requests go straight to the
// response. One request is worked at a time; the next word is taken the cycle after
// the response is loaded, which may still be waiting on rsp ready. Reset clears the
// entry count, state and rsp valid; table contents stay undefined and need no sweep.
module sorted_key_table #(
   parameter int DEPTH     = 64,
   parameter int KEY_WIDTH = 32
) (
   input  logic      clock,
   input  logic      reset,
   skt_req_if.sink   req_bus,
   skt_rsp_if.source rsp_bus
);

   skt_pkg::ctrl_cmd_type cmd;
   skt_pkg::dp_flags_type flags;

   skt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_mode  (req_bus.mode),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .flags     (flags),
      .cmd       (cmd)
   );

   skt_datapath #(
      .DEPTH     (DEPTH),
      .KEY_WIDTH (KEY_WIDTH)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .req_key      (req_bus.key),
      .req_index    (req_bus.index),
      .cmd          (cmd),
      .flags        (flags),
      .rsp_status   (rsp_bus.status),
      .rsp_position (rsp_bus.position),
      .rsp_key_out  (rsp_bus.key_out),
      .rsp_count    (rsp_bus.count)
   );

endmodule
